/* design/mnsp_pkg.sv */
// Shared types and constants for the MIDI note solenoid pulser.
package mnsp_pkg;

  localparam int CHANNELS_DEFAULT = 8;
  localparam int CNT_W = 7;
  localparam int MASK_W = 8;
  localparam int NOTE_W = 7;
  localparam int VEL_W = 7;
  localparam int STATUS_W = 8;
  localparam int NOTE_RANGE = 2 ** NOTE_W;
  localparam int VEL_RANGE = 2 ** VEL_W;

  localparam logic [STATUS_W-1:0] MSG_TYPE_MASK = 8'hF0;
  localparam logic [STATUS_W-1:0] MSG_NOTE_ON = 8'h90;
  localparam logic [CNT_W-1:0] LED_PULSE_RESET = 7'd100;

  // Longest pulse is 1 + 99 ticks; velocity is scaled onto that range.
  localparam int PULSE_SCALE = 99;
  localparam int VEL_FULL = 127;

  typedef enum logic {
    REQ_MIDI = 1'b0,
    REQ_TICK = 1'b1
  } req_type_t;

endpackage

/* design/midi_note_solenoid_pulser.sv */
// Top level of the MIDI note solenoid pulser: channel countdowns, LED timer and output skid.
//
// Usage: each input transaction on the s_axis group is either a MIDI message
// (tuser low) or a one-millisecond tick (tuser high). A Note On with nonzero
// velocity starts or retriggers a pulse on channel note mod CHANNELS lasting
// 1 + velocity*99/127 ticks; any MIDI message reloads the LED timer with the
// value last written on the cfg port. Ticks count every running timer down.
// Every input transaction yields exactly one output transaction on m_axis
// carrying the solenoid mask, LED state and a pulse-start flag as they stand
// after that item.
// The result is registered: it goes to the output register, or to the skid
// register while the receiver stalls. Throughput is one item per cycle while the skid
// register is empty, set by the single pass from the timer registers to the output register.
// When the receiver stalls, one further result is held in a skid register;
// s_axis_tready drops only while that skid register is occupied.
// Reset clears all timers and the output side and sets the LED time to 100.
// The cfg port is written only while the block is idle; the user must keep to this, the block does not enforce it.
module midi_note_solenoid_pulser #(
  parameter int CHANNELS = mnsp_pkg::CHANNELS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // status_byte[7:0], note[14:8], velocity[21:15], zeros
  input  logic        s_axis_tuser,   // req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // solenoid_mask[7:0], led_on[8], pulse_started[9], zeros
  input  logic        cfg_wr_en,
  input  logic [6:0]  cfg_wr_data     // led_pulse_ms
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int RES_W = mnsp_pkg::MASK_W + 2;

  logic [mnsp_pkg::STATUS_W-1:0] status_byte;
  logic [mnsp_pkg::NOTE_W-1:0]   note;
  logic [mnsp_pkg::VEL_W-1:0]    velocity;
  mnsp_pkg::req_type_t           req_type;

  assign status_byte = s_axis_tdata[7:0];
  assign note        = s_axis_tdata[14:8];
  assign velocity    = s_axis_tdata[21:15];
  assign req_type    = mnsp_pkg::req_type_t'(s_axis_tuser);

  logic accept;
  logic is_midi;
  logic is_tick;
  logic start_pulse;

  assign accept      = s_axis_tvalid && s_axis_tready;
  assign is_midi     = accept && (req_type == mnsp_pkg::REQ_MIDI);
  assign is_tick     = accept && (req_type == mnsp_pkg::REQ_TICK);
  assign start_pulse = is_midi
                       && ((status_byte & mnsp_pkg::MSG_TYPE_MASK) == mnsp_pkg::MSG_NOTE_ON)
                       && (velocity != '0);

  // Constant lookup tables, filled at elaboration: note to channel, velocity to length.
  logic [CH_W-1:0]            chan_of_note [mnsp_pkg::NOTE_RANGE];
  logic [mnsp_pkg::CNT_W-1:0] ticks_of_vel [mnsp_pkg::VEL_RANGE];

  for (genvar n = 0; n < mnsp_pkg::NOTE_RANGE; n++) begin : g_note_tbl
    localparam int CH_OF_N = n % CHANNELS;
    assign chan_of_note[n] = CH_W'(CH_OF_N);
  end

  for (genvar v = 0; v < mnsp_pkg::VEL_RANGE; v++) begin : g_vel_tbl
    localparam int TICKS_OF_V = 1 + (v * mnsp_pkg::PULSE_SCALE) / mnsp_pkg::VEL_FULL;
    assign ticks_of_vel[v] = mnsp_pkg::CNT_W'(TICKS_OF_V);
  end

  logic [CH_W-1:0]            sel_chan;
  logic [mnsp_pkg::CNT_W-1:0] pulse_len;

  assign sel_chan  = chan_of_note[note];
  assign pulse_len = ticks_of_vel[velocity];

  // LED on-time register.
  logic [mnsp_pkg::CNT_W-1:0] led_pulse_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      led_pulse_ms <= mnsp_pkg::LED_PULSE_RESET;
    end else if (cfg_wr_en) begin
      led_pulse_ms <= cfg_wr_data;
    end
  end

  logic [CHANNELS-1:0] chan_active_next;
  logic                led_active_next;

  for (genvar i = 0; i < CHANNELS; i++) begin : g_chan
    mnsp_countdown u_chan (
      .clk         (clk),
      .rst         (rst),
      .load        (start_pulse && (sel_chan == CH_W'(i))),
      .load_value  (pulse_len),
      .tick        (is_tick),
      .active_next (chan_active_next[i])
    );
  end

  mnsp_countdown u_led (
    .clk         (clk),
    .rst         (rst),
    .load        (is_midi),
    .load_value  (led_pulse_ms),
    .tick        (is_tick),
    .active_next (led_active_next)
  );

  // Only the first eight channels are visible in the mask.
  logic [mnsp_pkg::MASK_W-1:0] mask_next;

  for (genvar b = 0; b < mnsp_pkg::MASK_W; b++) begin : g_mask
    if (b < CHANNELS) begin : g_used
      assign mask_next[b] = chan_active_next[b];
    end else begin : g_unused
      assign mask_next[b] = 1'b0;
    end
  end

  logic [RES_W-1:0] result_next;
  assign result_next = {start_pulse, led_active_next, mask_next};

  // Output register plus one skid entry.
  logic             out_valid;
  logic [RES_W-1:0] out_data;
  logic             skid_valid;
  logic [RES_W-1:0] skid_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || m_axis_tready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid  <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || m_axis_tready) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else begin
        out_data <= result_next;
      end
    end else if (accept) begin
      skid_data <= result_next;
    end
  end

  assign s_axis_tready = !skid_valid;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(16 - RES_W){1'b0}}, out_data};

endmodule

/* design/mnsp_countdown.sv */
// One millisecond countdown with load and tick, reporting activity after the update.
module mnsp_countdown (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      load,
  input  logic [mnsp_pkg::CNT_W-1:0] load_value,
  input  logic                      tick,
  output logic                      active_next
);

  logic [mnsp_pkg::CNT_W-1:0] count;
  logic [mnsp_pkg::CNT_W-1:0] count_next;

  always_comb begin
    count_next = count;
    if (load) begin
      count_next = load_value;
    end else if (tick && (count != '0)) begin
      count_next = count - mnsp_pkg::CNT_W'(1);
    end
  end

  assign active_next = (count_next != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

endmodule

/* sim/mnsp_result_checker.sv */
// Checker for the solenoid pulser: it watches both streams and the cfg port, predicts and compares.
module mnsp_result_checker
  import mnsp_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [23:0] s_tdata,    // status_byte[7:0], note[14:8], velocity[21:15], zeros
  input  logic        s_tuser,    // req_type
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,    // solenoid_mask[7:0], led_on[8], pulse_started[9], zeros
  input  logic        cfg_wr_en,
  input  logic [6:0]  cfg_wr_data,
  output int          fail_count,
  output int          pending,
  output int          results_checked,
  output int          ticks_seen,
  output int          pulses_started
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [MASK_W-1:0] mask;
    logic              led;
    logic              started;
  } pulser_result_t;

  logic [CNT_W-1:0] pulse_left [CHANNELS];
  logic [CNT_W-1:0] led_left;
  logic [CNT_W-1:0] led_time;
  pulser_result_t   expected_results [$];

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    fail_count++;
  endtask

  // Updates the timers for one accepted item and queues the result it must produce.
  task automatic predict_outputs(req_type_t kind, logic [STATUS_W-1:0] status,
                                 logic [NOTE_W-1:0] note, logic [VEL_W-1:0] vel);
    pulser_result_t r;
    int             ch;
    r = '0;
    if (kind == REQ_TICK) begin
      ticks_seen++;
      for (int i = 0; i < CHANNELS; i++) begin
        if (pulse_left[i] != '0) pulse_left[i] = pulse_left[i] - CNT_W'(1);
      end
      if (led_left != '0) led_left = led_left - CNT_W'(1);
    end else begin
      led_left = led_time;
      if ((status & MSG_TYPE_MASK) == MSG_NOTE_ON && vel != '0) begin
        ch = int'(note) % CHANNELS;
        pulse_left[ch] = CNT_W'(1 + (int'(vel) * PULSE_SCALE) / VEL_FULL);
        r.started = 1'b1;
        pulses_started++;
      end
    end
    for (int i = 0; i < CHANNELS && i < MASK_W; i++) begin
      r.mask[i] = (pulse_left[i] != '0);
    end
    r.led = (led_left != '0);
    expected_results.push_back(r);
  endtask

  always @(posedge clk) begin
    pulser_result_t want;
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) pulse_left[i] = '0;
      led_left = '0;
      led_time = LED_PULSE_RESET;
      expected_results.delete();
    end else begin
      if (cfg_wr_en) led_time = cfg_wr_data;
      // Results are taken before new items, so a result can never match its own input.
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing expected", int'(m_tdata), 0);
        end else begin
          want = expected_results.pop_front();
          results_checked++;
          if (m_tdata[7:0] !== want.mask)
            report_mismatch("solenoid_mask", int'(m_tdata[7:0]), int'(want.mask));
          if (m_tdata[8] !== want.led)
            report_mismatch("led_on", int'(m_tdata[8]), int'(want.led));
          if (m_tdata[9] !== want.started)
            report_mismatch("pulse_started", int'(m_tdata[9]), int'(want.started));
        end
      end
      if (s_tvalid && s_tready) begin
        predict_outputs(req_type_t'(s_tuser), s_tdata[7:0], s_tdata[14:8], s_tdata[21:15]);
      end
    end
    pending = expected_results.size();
  end

endmodule

/* sim/tb_top.sv */
// Top of the solenoid pulser testbench: clock, reset, stimulus, output stalls and verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mnsp_pkg::*;

  localparam logic [STATUS_W-1:0] MSG_NOTE_OFF = 8'h80;
  localparam int LONG_HOLD = 60;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        cfg_wr_en = 1'b0;
  logic [6:0]  cfg_wr_data = '0;

  int fail_count;
  int expected_pending;
  int results_checked;
  int ticks_seen;
  int pulses_started;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;
  int holds_served = 0;
  int hold_left = 0;
  int items_sent = 0;

  always #5 clk = ~clk;

  midi_note_solenoid_pulser uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  mnsp_result_checker checker_i (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_axis_tvalid),
    .s_tready        (s_axis_tready),
    .s_tdata         (s_axis_tdata),
    .s_tuser         (s_axis_tuser),
    .m_tvalid        (m_axis_tvalid),
    .m_tready        (m_axis_tready),
    .m_tdata         (m_axis_tdata),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .fail_count      (fail_count),
    .pending         (expected_pending),
    .results_checked (results_checked),
    .ticks_seen      (ticks_seen),
    .pulses_started  (pulses_started)
  );

  // Output side: random stalls, plus a long hold-off whenever the stimulus asks for one.
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left--;
    end else if (hold_requests != holds_served) begin
      holds_served++;
      hold_left = LONG_HOLD - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    #3_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic send_item(req_type_t kind, logic [STATUS_W-1:0] status,
                           logic [NOTE_W-1:0] note, logic [VEL_W-1:0] vel);
    @(negedge clk);
    if (send_idle_pct > 0) begin
      while ($urandom_range(99) < send_idle_pct) begin
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {2'b00, vel, note, status};
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
  endtask

  // Sender stops until every queued result has come back.
  task automatic wait_drained();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (expected_pending != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_led_time(logic [6:0] value);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Mostly Note On and ticks so pulses start, overlap and expire; the rest is other traffic.
  task automatic send_random_item();
    int                  pick;
    logic [STATUS_W-1:0] status;
    logic [NOTE_W-1:0]   note;
    logic [VEL_W-1:0]    vel;
    pick   = $urandom_range(99);
    status = STATUS_W'($urandom);
    note   = NOTE_W'($urandom);
    vel    = VEL_W'($urandom);
    if (pick < 45) begin
      send_item(REQ_TICK, status, note, vel);
    end else if (pick < 75) begin
      send_item(REQ_MIDI, MSG_NOTE_ON | {4'h0, status[3:0]}, note,
                VEL_W'($urandom_range(127, 1)));
    end else if (pick < 82) begin
      send_item(REQ_MIDI, MSG_NOTE_ON | {4'h0, status[3:0]}, note, '0);
    end else if (pick < 89) begin
      send_item(REQ_MIDI, MSG_NOTE_OFF | {4'h0, status[3:0]}, note, vel);
    end else begin
      send_item(REQ_MIDI, status, note, vel);
    end
  endtask

  task automatic run_random(int count);
    int sent;
    int burst;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(99) < 6) begin
        burst = $urandom_range(40, 10);
        repeat (burst) begin
          send_item(REQ_TICK, STATUS_W'($urandom), NOTE_W'($urandom), VEL_W'($urandom));
        end
        sent += burst;
      end else begin
        send_random_item();
        sent++;
      end
    end
  endtask

  initial begin
    logic [6:0] mid_led_time;
    mid_led_time = 7'($urandom_range(126, 2));
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // Directed part at the reset LED time, with mild idling on both sides.
    send_idle_pct = 16;
    recv_idle_pct = 45;
    send_item(REQ_MIDI, MSG_NOTE_ON, 7'd0, 7'd127);
    send_item(REQ_MIDI, MSG_NOTE_ON, 7'd127, 7'd1);
    send_item(REQ_MIDI, MSG_NOTE_ON | 8'h0F, 7'd10, 7'd2);
    send_item(REQ_MIDI, MSG_NOTE_ON, 7'd8, 7'd0);
    send_item(REQ_MIDI, MSG_NOTE_OFF, 7'd3, 7'd127);
    send_item(REQ_MIDI, MSG_NOTE_ON | 8'h05, 7'd13, 7'd64);
    send_item(REQ_MIDI, MSG_NOTE_ON, 7'd21, 7'd90);
    send_item(REQ_MIDI, 8'hFF, 7'd127, 7'd127);
    send_item(REQ_MIDI, 8'h00, 7'd0, 7'd0);
    send_item(REQ_MIDI, 8'hA0, 7'd4, 7'd100);
    send_item(REQ_MIDI, 8'hF0, 7'd6, 7'd127);
    send_item(REQ_TICK, 8'hFF, 7'd127, 7'd127);
    send_item(REQ_TICK, MSG_NOTE_ON, 7'd1, 7'd127);
    send_item(REQ_TICK, 8'h00, 7'd0, 7'd0);
    // Retrigger a channel that is still running, then start channels 1, 4, 6 and 7.
    send_item(REQ_MIDI, MSG_NOTE_ON, 7'd16, 7'd3);
    send_item(REQ_MIDI, MSG_NOTE_ON, 7'd1, 7'd126);
    send_item(REQ_MIDI, MSG_NOTE_ON, 7'd4, 7'd33);
    send_item(REQ_MIDI, MSG_NOTE_ON, 7'd6, 7'd77);
    send_item(REQ_MIDI, MSG_NOTE_ON, 7'd15, 7'd50);
    send_item(REQ_TICK, 8'h00, 7'd0, 7'd0);
    send_item(REQ_TICK, 8'h00, 7'd0, 7'd0);
    send_item(REQ_TICK, 8'h00, 7'd0, 7'd0);

    write_led_time(7'd1);
    run_random(300);

    send_idle_pct = 45;
    recv_idle_pct = 16;
    write_led_time(7'd127);
    run_random(300);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_led_time(7'd0);
    run_random(50);

    write_led_time(mid_led_time);
    // The output stalls for a long stretch while items keep coming, so the input backs up.
    hold_requests++;
    repeat (25) send_random_item();
    wait_drained();
    run_random(225);

    wait_drained();
    repeat (8) @(negedge clk);
    $display("Covered %0d items: %0d ticks, %0d pulse starts, %0d results compared.",
             items_sent, ticks_seen, pulses_started, results_checked);
    $display("LED times 100, 1, 127, 0 and %0d; three idling patterns and a long output stall.",
             mid_led_time);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
